@@ sv/rfd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_pkg
// Shared types and constants of the ranging frame deframer.
// ----------------------------------------------------------------------------
package rfd_pkg;

   localparam int BYTE_W   = 8;
   localparam int RAW_W    = 16;
   localparam int DIST_W   = 12;
   localparam int CHAN_W   = 4;
   localparam int IDX_W    = 5;
   localparam int CSR_IDX_W = 1;

   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h56;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4C;

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_LIMIT  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_LIMIT = 1'b1;

   localparam logic [DIST_W-1:0] LOW_LIMIT_RST  = 12'd10;
   localparam logic [DIST_W-1:0] HIGH_LIMIT_RST = 12'd1200;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_HDR2,
      PH_DATA,
      PH_SUM,
      PH_EMIT_RD,
      PH_EMIT_CALC
   } phase_type;

endpackage : rfd_pkg
`default_nettype wire

@@ sv/rfd_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module rfd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : rfd_ram
`default_nettype wire

@@ sv/ranging_frame_deframer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ranging_frame_deframer
// Hunts for a 'V','L' header, collects big-endian 16-bit distance words into
// a raw memory with a modulo-256 byte sum, checks the trailing checksum and
// on a match clamps, commits and reports one beat per channel.
// Order: a byte beat is accepted while req_tready is high; the first result
// beat after the checksum passes PH_EMIT_RD, PH_EMIT_CALC, then the rsp register.
// Throughput: one byte per cycle while parsing; the report burst does a memory
// read, then modify and write back, per channel, with req_tready low all along,
// and it lasts longer if rsp_tready stalls.
// Reset: synchronous; limits go to 10 and 1200, the parser hunts, committed
// values read as zero through per-channel valid flags, raw memory not cleared.
// ----------------------------------------------------------------------------
module ranging_frame_deframer #(
   parameter int CHANNEL_COUNT = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: rx_byte[7:0]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,
   // rsp_tdata: channel[3:0], distance[15:4]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,
   // rsp_tuser: updated[0]
   output logic             rsp_tuser,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [rfd_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rfd_pkg::DIST_W-1:0]    csr_wdata
);

   import rfd_pkg::*;

   localparam int AW = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
   localparam logic [IDX_W-1:0]  LAST_BYTE = IDX_W'(2 * CHANNEL_COUNT - 1);
   localparam logic [CHAN_W-1:0] LAST_CH   = CHAN_W'(CHANNEL_COUNT - 1);

   phase_type         phase_ff, phase_in;
   logic [IDX_W-1:0]  byte_idx_ff, byte_idx_in;
   logic [BYTE_W-1:0] hi_hold_ff, hi_hold_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [CHAN_W-1:0] ch_ff, ch_in;
   logic [DIST_W-1:0] low_ff, high_ff;

   logic [CHANNEL_COUNT-1:0] com_vld_ff;
   logic                     com_vld_rd_ff;

   logic              rsp_valid_ff;
   logic [CHAN_W-1:0] rsp_chan_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   logic              rsp_upd_ff;
   logic              rsp_last_ff;

   logic              accept;
   logic              raw_we, rd_en, com_we, load_out, out_free;
   logic [RAW_W-1:0]  raw_q;
   logic [DIST_W-1:0] com_q, com_old, new_val, out_val;
   logic              upd;
   logic [AW-1:0]     ch_addr;

   assign ch_addr  = ch_ff[AW-1:0];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (phase_ff != PH_EMIT_RD) && (phase_ff != PH_EMIT_CALC);
   assign accept   = req_tvalid && req_tready;

   rfd_ram #(.WIDTH(RAW_W), .DEPTH(CHANNEL_COUNT), .AW(AW)) u_raw_ram (
      .clock   (clock),
      .wr_en   (raw_we),
      .wr_addr (byte_idx_ff[AW:1]),
      .wr_data ({hi_hold_ff, req_tdata}),
      .rd_en   (rd_en),
      .rd_addr (ch_addr),
      .rd_data (raw_q)
   );

   rfd_ram #(.WIDTH(DIST_W), .DEPTH(CHANNEL_COUNT), .AW(AW)) u_com_ram (
      .clock   (clock),
      .wr_en   (com_we),
      .wr_addr (ch_addr),
      .wr_data (new_val),
      .rd_en   (rd_en),
      .rd_addr (ch_addr),
      .rd_data (com_q)
   );

   // clamp and keep-old selection
   assign upd     = raw_q > {4'b0000, low_ff};
   assign new_val = (raw_q > {4'b0000, high_ff}) ? high_ff : raw_q[DIST_W-1:0];
   assign com_old = com_vld_rd_ff ? com_q : '0;
   assign out_val = upd ? new_val : com_old;

   always_comb begin
      phase_in    = phase_ff;
      byte_idx_in = byte_idx_ff;
      hi_hold_in  = hi_hold_ff;
      sum_in      = sum_ff;
      ch_in       = ch_ff;
      raw_we      = 1'b0;
      rd_en       = 1'b0;
      com_we      = 1'b0;
      load_out    = 1'b0;
      unique case (phase_ff)
         PH_HUNT: begin
            if (accept && req_tdata == HDR_FIRST) begin
               phase_in = PH_HDR2;
            end
         end
         PH_HDR2: begin
            if (accept) begin
               if (req_tdata == HDR_SECOND) begin
                  phase_in    = PH_DATA;
                  byte_idx_in = '0;
                  sum_in      = '0;
               end else if (req_tdata != HDR_FIRST) begin
                  phase_in = PH_HUNT;
               end
            end
         end
         PH_DATA: begin
            if (accept) begin
               sum_in = sum_ff + req_tdata;
               if (!byte_idx_ff[0]) begin
                  hi_hold_in = req_tdata;
               end else begin
                  raw_we = 1'b1;
               end
               byte_idx_in = byte_idx_ff + 1'b1;
               if (byte_idx_ff == LAST_BYTE) begin
                  phase_in = PH_SUM;
               end
            end
         end
         PH_SUM: begin
            if (accept) begin
               phase_in    = (req_tdata == sum_ff) ? PH_EMIT_RD : PH_HUNT;
               ch_in       = '0;
               byte_idx_in = '0;
               sum_in      = '0;
            end
         end
         PH_EMIT_RD: begin
            rd_en    = 1'b1;
            phase_in = PH_EMIT_CALC;
         end
         PH_EMIT_CALC: begin
            if (out_free) begin
               load_out = 1'b1;
               com_we   = upd;
               if (ch_ff == LAST_CH) begin
                  phase_in = PH_HUNT;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  phase_in = PH_EMIT_RD;
               end
            end
         end
         default: begin
            phase_in = PH_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         byte_idx_ff <= '0;
         hi_hold_ff  <= '0;
         sum_ff      <= '0;
         ch_ff       <= '0;
      end else begin
         phase_ff    <= phase_in;
         byte_idx_ff <= byte_idx_in;
         hi_hold_ff  <= hi_hold_in;
         sum_ff      <= sum_in;
         ch_ff       <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= LOW_LIMIT_RST;
         high_ff <= HIGH_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LOW_LIMIT:  low_ff  <= csr_wdata;
            CSR_HIGH_LIMIT: high_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         com_vld_ff <= '0;
      end else if (com_we) begin
         com_vld_ff[ch_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         com_vld_rd_ff <= com_vld_ff[ch_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_chan_ff <= ch_ff;
         rsp_dist_ff <= out_val;
         rsp_upd_ff  <= upd;
         rsp_last_ff <= (ch_ff == LAST_CH);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_dist_ff, rsp_chan_ff};
   assign rsp_tuser  = rsp_upd_ff;
   assign rsp_tlast  = rsp_last_ff;

   // good checksum starts the report burst
   assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_SUM && req_tdata == sum_ff) |=> phase_ff == PH_EMIT_RD)
      else $error("good checksum did not start report");

   // last beat of a burst carries the final channel
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tdata[CHAN_W-1:0] == LAST_CH)
      else $error("tlast on wrong channel");

   // burst ends back in hunting after the final channel
   assert property (@(posedge clock) disable iff (reset)
      (load_out && ch_ff == LAST_CH) |=> phase_ff == PH_HUNT)
      else $error("parser did not return to hunting");

   // commits only happen while reporting
   assert property (@(posedge clock) disable iff (reset)
      com_we |-> (phase_ff == PH_EMIT_CALC && load_out))
      else $error("commit outside report");

endmodule : ranging_frame_deframer
`default_nettype wire
